// ===== src/tlbpt_pkg.sv =====
// shared constants and types for the tlb page translator
`timescale 1ns / 1ps
package tlbpt_pkg;
  localparam int TlbDepth   = 16;
  localparam int FrameCount = 128;
  localparam int OffsetBits = 8;
  localparam int VaWidth    = 16;
  localparam int PaWidth    = 15;
  localparam int FrameWidth = 7;
  localparam int CountWidth = 16;
  localparam logic [CountWidth-1:0] CountMax = 16'hFFFF;

  // controller to datapath commands
  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_TLB_SEARCH,
    CMD_FRAME_SEARCH,
    CMD_SWEEP,
    CMD_DROP,
    CMD_FINISH
  } cmd_t;

  // datapath status back to controller
  typedef struct packed {
    logic tlb_found;
    logic tlb_done;
    logic frame_found;
    logic frame_done;
    logic victim_found;
    logic drop_done;
  } stat_t;
endpackage

// ===== src/tlbpt_if.sv =====
// valid/ready channel interface
`timescale 1ns / 1ps
interface tlbpt_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/tlb_page_translate_clock_unit.sv =====
// top level of the tlb page translator with clock replacement
`timescale 1ns / 1ps
// usage:
//   in carries one 16-bit virtual address per item; out carries one result
//   item per input: physical address, frame, tlb hit, page fault and the
//   saturating hit and fault counts.
// sequence:
//   items are handled one at a time; a new item is not taken before the
//   result of the last one appears. an item probes the valid tlb entries in
//   order; on a tlb miss the frame memory is scanned through its single read
//   port; on a fault the clock hand steps to a victim and a purge pass drops
//   the tlb entries mapping the victim. every item ends in the finish step.
// reset:
//   synchronous rst empties the tlb, marks all frames unloaded, clears
//   reference bits, the clock hand and both counters; no clearing pass.
// stall:
//   a result waits in the output register; a new item is taken only when
//   that register is free or being emptied.
module tlb_page_translate_clock_unit #(
  parameter int TLB_DEPTH   = tlbpt_pkg::TlbDepth,
  parameter int FRAME_COUNT = tlbpt_pkg::FrameCount,
  parameter int OFFSET_BITS = tlbpt_pkg::OffsetBits
) (
  input logic clk,
  input logic rst,
  tlbpt_if.sink   in_ch,
  tlbpt_if.source out_ch
);
  tlbpt_pkg::cmd_t  cmd;
  tlbpt_pkg::stat_t stat;
  logic out_busy;

  tlbpt_ctrl u_ctrl (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_busy, .stat, .cmd
  );

  tlbpt_dp #(.TLB_DEPTH(TLB_DEPTH), .FRAME_COUNT(FRAME_COUNT),
             .OFFSET_BITS(OFFSET_BITS)) u_dp (
    .clk, .rst, .cmd, .va(in_ch.data[tlbpt_pkg::VaWidth-1:0]), .stat, .out_busy,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .physical_address(out_ch.data[55:41]),
    .frame_number(out_ch.data[40:34]),
    .tlb_hit(out_ch.data[33]),
    .page_fault(out_ch.data[32]),
    .hits_so_far(out_ch.data[31:16]),
    .faults_so_far(out_ch.data[15:0])
  );
endmodule

// ===== src/tlbpt_ctrl.sv =====
// controller state machine for the translator
`timescale 1ns / 1ps
module tlbpt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_busy,
  input  tlbpt_pkg::stat_t stat,
  output tlbpt_pkg::cmd_t  cmd
);
  typedef enum logic [2:0] {S_IDLE, S_TLB, S_FRAME, S_SWEEP, S_DROP, S_FIN} state_t;
  state_t state;

  assign in_ready = (state == S_IDLE) && !out_busy;

  always_comb begin
    unique case (state)
      S_IDLE:  cmd = (in_valid && !out_busy) ? tlbpt_pkg::CMD_LOAD : tlbpt_pkg::CMD_IDLE;
      S_TLB:   cmd = tlbpt_pkg::CMD_TLB_SEARCH;
      S_FRAME: cmd = tlbpt_pkg::CMD_FRAME_SEARCH;
      S_SWEEP: cmd = tlbpt_pkg::CMD_SWEEP;
      S_DROP:  cmd = tlbpt_pkg::CMD_DROP;
      S_FIN:   cmd = tlbpt_pkg::CMD_FINISH;
      default: cmd = tlbpt_pkg::CMD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (in_valid && !out_busy) state <= S_TLB;
        S_TLB: begin
          if (stat.tlb_found) state <= S_FIN;
          else if (stat.tlb_done) state <= S_FRAME;
        end
        S_FRAME: begin
          if (stat.frame_found) state <= S_FIN;
          else if (stat.frame_done) state <= S_SWEEP;
        end
        S_SWEEP: if (stat.victim_found) state <= S_DROP;
        S_DROP:  if (stat.drop_done) state <= S_FIN;
        S_FIN:   state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fin_from_work: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |=> state == S_IDLE) else $error("finish did not return to idle");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE && !out_busy) else $error("accept while busy");
  a_sweep_to_drop: assert property (@(posedge clk) disable iff (rst)
    state == S_SWEEP && stat.victim_found |=> state == S_DROP)
    else $error("victim not followed by drop");
endmodule

// ===== src/tlbpt_dp.sv =====
// datapath: tlb queue, frame table, clock hand, counters, result register
`timescale 1ns / 1ps
module tlbpt_dp #(
  parameter int TLB_DEPTH   = tlbpt_pkg::TlbDepth,
  parameter int FRAME_COUNT = tlbpt_pkg::FrameCount,
  parameter int OFFSET_BITS = tlbpt_pkg::OffsetBits
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tlbpt_pkg::cmd_t                     cmd,
  input  logic [tlbpt_pkg::VaWidth-1:0]       va,
  output tlbpt_pkg::stat_t                    stat,
  output logic                                out_busy,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tlbpt_pkg::PaWidth-1:0]       physical_address,
  output logic [tlbpt_pkg::FrameWidth-1:0]    frame_number,
  output logic                                tlb_hit,
  output logic                                page_fault,
  output logic [tlbpt_pkg::CountWidth-1:0]    hits_so_far,
  output logic [tlbpt_pkg::CountWidth-1:0]    faults_so_far
);
  localparam int PageBits = tlbpt_pkg::VaWidth - OFFSET_BITS;
  localparam int FBits    = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int TBits    = $clog2(TLB_DEPTH);
  localparam int CBits    = $clog2(TLB_DEPTH + 1);
  localparam int FwBits   = FBits + OFFSET_BITS;

  logic [PageBits-1:0] tags [TLB_DEPTH];
  logic [FBits-1:0]    tfrm [TLB_DEPTH];
  logic [CBits-1:0]    fill;
  logic [PageBits-1:0] owner [FRAME_COUNT];
  logic [FRAME_COUNT-1:0] loaded, refb;
  logic [FBits-1:0]    hand, fidx, frame;
  logic [CBits-1:0]    tidx;
  logic [PageBits-1:0] page;
  logic [OFFSET_BITS-1:0] offs;
  logic                thit, fault;
  logic [tlbpt_pkg::CountWidth-1:0] hits, faults;
  logic [PageBits-1:0] owner_q;
  logic                owner_ok;
  logic [FBits-1:0]    owner_idx;
  logic [FwBits-1:0]   pa_full;

  // tlb probe at one entry per cycle
  logic [TBits-1:0] tsel;
  logic tlb_match, tlb_end;
  assign tsel      = tidx[TBits-1:0];
  assign tlb_end   = (tidx >= fill);
  assign tlb_match = !tlb_end && tags[tsel] == page;

  // frame table is a memory, read one entry per cycle with registered data
  logic frame_last;
  assign frame_last = (owner_idx == FBits'(FRAME_COUNT - 1));
  logic [FBits-1:0] hand_inc;
  assign hand_inc = (hand == FBits'(FRAME_COUNT - 1)) ? '0 : hand + 1'b1;
  // only a loaded frame can match
  logic owner_hit;
  assign owner_hit = owner_ok && loaded[owner_idx] && owner_q == page;

  assign stat.tlb_found    = (cmd == tlbpt_pkg::CMD_TLB_SEARCH) && tlb_match;
  assign stat.tlb_done     = (cmd == tlbpt_pkg::CMD_TLB_SEARCH) && tlb_end;
  assign stat.frame_found  = (cmd == tlbpt_pkg::CMD_FRAME_SEARCH) && owner_hit;
  assign stat.frame_done   = (cmd == tlbpt_pkg::CMD_FRAME_SEARCH) && owner_ok
                             && frame_last && !owner_hit;
  assign stat.victim_found = (cmd == tlbpt_pkg::CMD_SWEEP) && !refb[hand];
  assign stat.drop_done    = (cmd == tlbpt_pkg::CMD_DROP) && tlb_end;

  always_ff @(posedge clk) begin
    owner_q <= owner[fidx];
    if (cmd == tlbpt_pkg::CMD_DROP && tidx == '0) owner[frame] <= page;
  end

  assign pa_full = {frame, offs};
  assign out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0; loaded <= '0; refb <= '0; hand <= '0;
      hits <= '0; faults <= '0; out_valid <= 1'b0; owner_ok <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (cmd)
        tlbpt_pkg::CMD_LOAD: begin
          page <= va[tlbpt_pkg::VaWidth-1:OFFSET_BITS];
          offs <= va[OFFSET_BITS-1:0];
          tidx <= '0; fidx <= '0; thit <= 1'b0; fault <= 1'b0; owner_ok <= 1'b0;
        end
        tlbpt_pkg::CMD_TLB_SEARCH: begin
          if (tlb_match) begin
            frame <= tfrm[tsel]; thit <= 1'b1;
            for (int k = 0; k < TLB_DEPTH - 1; k++)
              if (k >= tidx) begin tags[k] <= tags[k+1]; tfrm[k] <= tfrm[k+1]; end
            fill <= fill - 1'b1;
          end else if (!tlb_end) tidx <= tidx + 1'b1;
        end
        tlbpt_pkg::CMD_FRAME_SEARCH: begin
          // owner_q is valid in the cycle after its address
          owner_ok  <= 1'b1;
          owner_idx <= fidx;
          if (fidx != FBits'(FRAME_COUNT - 1)) fidx <= fidx + 1'b1;
          if (owner_hit) begin
            frame <= owner_idx; refb[owner_idx] <= 1'b1;
          end
        end
        tlbpt_pkg::CMD_SWEEP: begin
          hand <= hand_inc; tidx <= '0;
          if (refb[hand]) refb[hand] <= 1'b0;
          else begin frame <= hand; fault <= 1'b1; end
        end
        tlbpt_pkg::CMD_DROP: begin
          // purge stale entries mapping the victim
          if (!tlb_end) begin
            if (loaded[frame] && tfrm[tsel] == frame) begin
              for (int k = 0; k < TLB_DEPTH - 1; k++)
                if (k >= tidx) begin tags[k] <= tags[k+1]; tfrm[k] <= tfrm[k+1]; end
              fill <= fill - 1'b1;
            end else tidx <= tidx + 1'b1;
          end else loaded[frame] <= 1'b1;
        end
        tlbpt_pkg::CMD_FINISH: begin
          if (thit && hits != tlbpt_pkg::CountMax) hits <= hits + 1'b1;
          if (fault && faults != tlbpt_pkg::CountMax) faults <= faults + 1'b1;
          if (fill >= CBits'(TLB_DEPTH)) begin
            for (int k = 0; k < TLB_DEPTH - 1; k++) begin
              tags[k] <= tags[k+1]; tfrm[k] <= tfrm[k+1];
            end
            tags[TLB_DEPTH-1] <= page; tfrm[TLB_DEPTH-1] <= frame;
          end else begin
            tags[fill[TBits-1:0]] <= page; tfrm[fill[TBits-1:0]] <= frame; fill <= fill + 1'b1;
          end
          physical_address <= tlbpt_pkg::PaWidth'(pa_full);
          frame_number     <= tlbpt_pkg::FrameWidth'(frame);
          tlb_hit          <= thit;
          page_fault       <= fault;
          hits_so_far      <= (thit && hits != tlbpt_pkg::CountMax) ? hits + 1'b1 : hits;
          faults_so_far    <= (fault && faults != tlbpt_pkg::CountMax) ? faults + 1'b1 : faults;
          out_valid        <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CBits'(TLB_DEPTH)) else $error("tlb fill overflow");
  a_not_both: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(tlb_hit && page_fault)) else $error("hit and fault together");
  a_victim_clear: assert property (@(posedge clk) disable iff (rst)
    stat.victim_found |-> !refb[hand]) else $error("victim has reference bit");
endmodule
